FILE: rtl/lidar_scan_binning_obstacle_detect_assert.svh
// assertion macros shared by the lidar binning checker
`ifndef LIDAR_SCAN_BINNING_OBSTACLE_DETECT_ASSERT_SVH
`define LIDAR_SCAN_BINNING_OBSTACLE_DETECT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define LSBOD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LSBOD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lsbod_pkg.sv
// shared types, widths and constants of the lidar binning block
package lsbod_pkg;

  // field widths
  localparam int OP_W       = 2;
  localparam int DIST_W     = 16;
  localparam int ANGLE_W    = 9;
  localparam int QUAL_W     = 6;
  localparam int US_W       = 8;
  localparam int RIDX_W     = 8;
  localparam int SECT_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // geometry
  localparam int BINS_DEF    = 240;
  localparam int ANGLE_RANGE = 360;
  // fraction bits of the reciprocal used for angle*BINS/360
  localparam int BIN_FRAC    = 18;

  // register reset values
  localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST   = 16'd2000;
  localparam logic [DIST_W-1:0]  MIN_OBST_DIST_RST  = 16'd128;
  localparam logic [DIST_W-1:0]  OBST_DIST_RST      = 16'd140;
  localparam logic [SECT_W-1:0]  SECTOR_FIRST_RST   = 8'd145;
  localparam logic [SECT_W-1:0]  SECTOR_LAST_RST    = 8'd210;
  localparam logic [US_W-1:0]    US_THRESHOLD_RST   = 8'd8;
  localparam logic [ANGLE_W-1:0] ANGLE_OFFSET_RST   = 9'd90;
  localparam logic [US_W-1:0]    US_NO_ECHO_RST     = 8'd50;
  localparam logic [US_W-1:0]    LAST_US_RST        = 8'd50;

  // item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_POINT      = 2'd0,
    OP_ULTRASONIC = 2'd1,
    OP_TICK       = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_DISTANCE  = 3'd0,
    REG_MIN_OBST_DIST = 3'd1,
    REG_OBST_DIST     = 3'd2,
    REG_SECTOR_FIRST  = 3'd3,
    REG_SECTOR_LAST   = 3'd4,
    REG_US_THRESHOLD  = 3'd5,
    REG_ANGLE_OFFSET  = 3'd6,
    REG_US_NO_ECHO    = 3'd7
  } cfg_reg_t;

endpackage

FILE: rtl/lsbod_ram.sv
// generic single write port ram with registered read
module lsbod_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 240
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/lsbod_angle_bin.sv
// maps a point angle, less the offset, to its bin and the bin before it
module lsbod_angle_bin
  import lsbod_pkg::*;
#(
  parameter int BINS = BINS_DEF
) (
  input  logic [ANGLE_W-1:0]      angle,
  input  logic [ANGLE_W-1:0]      offset,
  output logic [$clog2(BINS)-1:0] bin_idx,
  output logic [$clog2(BINS)-1:0] prev_idx
);

  localparam int IDX_W  = $clog2(BINS);
  // ceil(BINS * 2^BIN_FRAC / 360); error stays below one bin step for angles < 360
  localparam int MULT   = (BINS * (2 ** BIN_FRAC) + ANGLE_RANGE - 1) / ANGLE_RANGE;
  localparam int MULT_W = $clog2(MULT + 1);
  localparam int PROD_W = ANGLE_W + MULT_W;

  logic [ANGLE_W-1:0] angle_m;
  logic [ANGLE_W-1:0] offset_m;
  logic [ANGLE_W:0]   wrap_sum;
  logic [ANGLE_W-1:0] rel_angle;
  logic [PROD_W-1:0]  prod;

  // reduce both to 0..359 with one subtract each
  assign angle_m  = (angle >= ANGLE_W'(ANGLE_RANGE)) ? angle - ANGLE_W'(ANGLE_RANGE) : angle;
  assign offset_m = (offset >= ANGLE_W'(ANGLE_RANGE)) ? offset - ANGLE_W'(ANGLE_RANGE) : offset;

  // relative angle, wrapped into 0..359
  assign wrap_sum  = {1'b0, angle_m} + (ANGLE_W + 1)'(ANGLE_RANGE) - {1'b0, offset_m};
  assign rel_angle = (angle_m >= offset_m) ? angle_m - offset_m : wrap_sum[ANGLE_W-1:0];

  // angle * BINS / 360 through the scaled reciprocal
  assign prod    = PROD_W'(rel_angle) * PROD_W'(MULT);
  assign bin_idx = prod[BIN_FRAC +: IDX_W];

  // neighbor bin, bin 0 wraps to the last bin
  assign prev_idx = (bin_idx == '0) ? IDX_W'(BINS - 1) : bin_idx - 1'b1;

endmodule

FILE: rtl/lidar_scan_binning_obstacle_detect.sv
// top level: lidar point binning with forward obstacle flag
//
//   channel   dir   handshake           payload
//   in_       in    in_valid/in_stall   op, point fields, ultrasonic, read index
//   out_      out   out_valid/out_stall obstacle, accepted, bin index/value, cleared
//   cfg_      in    cfg_we              cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low; a result passes the
// input register, the bin lookup with ram read and the result register in turn.
// The bin ram has one write and one read port; a same-cycle write is forwarded.
// Bin valid bits reset with rst_n, so no clearing pass is needed after reset.
// out_stall holds the result register and backs up the stages behind it.
module lidar_scan_binning_obstacle_detect
  import lsbod_pkg::*;
#(
  parameter int BINS = BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_op,
  input  logic [DIST_W-1:0]     in_point_distance,
  input  logic [ANGLE_W-1:0]    in_point_angle,
  input  logic [QUAL_W-1:0]     in_point_quality,
  input  logic [US_W-1:0]       in_ultrasonic_cm,
  input  logic [RIDX_W-1:0]     in_read_index,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_obstacle,
  output logic                  out_point_accepted,
  output logic [RIDX_W-1:0]     out_bin_index,
  output logic [DIST_W-1:0]     out_bin_value,
  output logic                  out_frame_cleared,
  // configuration port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(BINS);

  // configuration registers
  logic [DIST_W-1:0]  max_dist_r;
  logic [DIST_W-1:0]  min_obst_r;
  logic [DIST_W-1:0]  obst_dist_r;
  logic [SECT_W-1:0]  sect_first_r;
  logic [SECT_W-1:0]  sect_last_r;
  logic [US_W-1:0]    us_thr_r;
  logic [ANGLE_W-1:0] angle_off_r;
  logic [US_W-1:0]    us_no_echo_r;

  // stage 1: input register
  logic               s1_valid_r;
  op_t                s1_op_r;
  logic [DIST_W-1:0]  s1_dist_r;
  logic [ANGLE_W-1:0] s1_angle_r;
  logic [QUAL_W-1:0]  s1_qual_r;
  logic [US_W-1:0]    s1_us_r;
  logic [RIDX_W-1:0]  s1_ridx_r;

  // stage 2: bin resolved, ram read in flight
  logic               s2_valid_r;
  op_t                s2_op_r;
  logic [DIST_W-1:0]  s2_dist_r;
  logic               s2_accept_r;
  logic [IDX_W-1:0]   s2_idx_r;
  logic [IDX_W-1:0]   s2_rd_idx_r;
  logic               s2_rd_ok_r;
  logic [RIDX_W-1:0]  s2_ridx_r;
  logic [US_W-1:0]    s2_us_r;
  logic               fwd_hit_r;
  logic [DIST_W-1:0]  fwd_data_r;

  // block state
  logic [BINS-1:0]    bin_valid_r;
  logic               obst_flag_r;
  logic               obst_flag_nxt;
  logic [US_W-1:0]    last_us_r;

  // result register
  logic               out_valid_r;
  logic               out_obstacle_r;
  logic               out_accepted_r;
  logic [RIDX_W-1:0]  out_index_r;
  logic [DIST_W-1:0]  out_value_r;
  logic               out_cleared_r;

  // flow control
  logic               out_free;
  logic               s2_go;
  logic               s1_go;
  logic               in_take;

  // stage 1 logic
  logic [IDX_W-1:0]   bin_idx;
  logic [IDX_W-1:0]   prev_idx;
  logic               s1_accept;
  logic               s1_ridx_ok;
  logic [IDX_W-1:0]   ram_raddr;
  logic [DIST_W-1:0]  ram_rdata;

  // stage 2 logic
  logic [DIST_W-1:0]  rd_data;
  logic [DIST_W-1:0]  rd_val;
  logic [DIST_W-1:0]  pt_val;
  logic               in_sector;
  logic               obst_set;
  logic               obst_clr;
  logic               point_store;
  logic               tick_clear;
  logic               wr_en;
  logic [RIDX_W-1:0]  res_index;
  logic [DIST_W-1:0]  res_value;

  // handshake: a stage moves when the one ahead is empty or moving
  assign out_free = !out_valid_r || !out_stall;
  assign s2_go    = s2_valid_r && out_free;
  assign s1_go    = s1_valid_r && (!s2_valid_r || s2_go);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r   <= MAX_DISTANCE_RST;
      min_obst_r   <= MIN_OBST_DIST_RST;
      obst_dist_r  <= OBST_DIST_RST;
      sect_first_r <= SECTOR_FIRST_RST;
      sect_last_r  <= SECTOR_LAST_RST;
      us_thr_r     <= US_THRESHOLD_RST;
      angle_off_r  <= ANGLE_OFFSET_RST;
      us_no_echo_r <= US_NO_ECHO_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_DISTANCE:  max_dist_r   <= cfg_data;
        REG_MIN_OBST_DIST: min_obst_r   <= cfg_data;
        REG_OBST_DIST:     obst_dist_r  <= cfg_data;
        REG_SECTOR_FIRST:  sect_first_r <= cfg_data[SECT_W-1:0];
        REG_SECTOR_LAST:   sect_last_r  <= cfg_data[SECT_W-1:0];
        REG_US_THRESHOLD:  us_thr_r     <= cfg_data[US_W-1:0];
        REG_ANGLE_OFFSET:  angle_off_r  <= cfg_data[ANGLE_W-1:0];
        REG_US_NO_ECHO:    us_no_echo_r <= cfg_data[US_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r    <= op_t'(in_op);
      s1_dist_r  <= in_point_distance;
      s1_angle_r <= in_point_angle;
      s1_qual_r  <= in_point_quality;
      s1_us_r    <= in_ultrasonic_cm;
      s1_ridx_r  <= in_read_index;
    end
  end

  // angle to bin
  lsbod_angle_bin #(
    .BINS (BINS)
  ) u_angle_bin (
    .angle    (s1_angle_r),
    .offset   (angle_off_r),
    .bin_idx  (bin_idx),
    .prev_idx (prev_idx)
  );

  // point filter and ram read address
  assign s1_accept  = (s1_dist_r < max_dist_r) && (s1_qual_r != '0);
  assign s1_ridx_ok = 32'(s1_ridx_r) < 32'(BINS);
  assign ram_raddr  = (s1_op_r == OP_READ) ? IDX_W'(s1_ridx_r) : prev_idx;

  // bin distance store
  lsbod_ram #(
    .WIDTH (DIST_W),
    .DEPTH (BINS)
  ) u_bin_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s2_idx_r),
    .wdata (pt_val),
    .re    (s1_go),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // stage 2 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_go) begin
      s2_valid_r <= 1'b1;
    end else if (s2_go) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_op_r     <= s1_op_r;
      s2_dist_r   <= s1_dist_r;
      s2_accept_r <= s1_accept;
      s2_idx_r    <= bin_idx;
      s2_rd_idx_r <= ram_raddr;
      s2_rd_ok_r  <= (s1_op_r != OP_READ) || s1_ridx_ok;
      s2_ridx_r   <= s1_ridx_r;
      s2_us_r     <= s1_us_r;
      // catch a write to the same bin landing with the read
      fwd_hit_r   <= wr_en && (s2_idx_r == ram_raddr);
      fwd_data_r  <= pt_val;
    end
  end

  // bin read through forwarding and valid bit
  assign rd_data = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign rd_val  = (s2_rd_ok_r && bin_valid_r[s2_rd_idx_r]) ? rd_data : '0;

  // missing distance takes the neighbor bin
  assign pt_val = (s2_dist_r == '0) ? rd_val : s2_dist_r;

  // forward sector decision
  assign in_sector = (pt_val >= min_obst_r)
                  && (32'(s2_idx_r) >= 32'(sect_first_r))
                  && (32'(s2_idx_r) <= 32'(sect_last_r));
  assign obst_set  = (in_sector && (pt_val <= obst_dist_r)) || (last_us_r <= us_thr_r);
  assign obst_clr  = in_sector && (pt_val > obst_dist_r) && (last_us_r > us_thr_r);

  assign point_store = (s2_op_r == OP_POINT) && s2_accept_r;
  assign tick_clear  = (s2_op_r == OP_TICK) && !obst_flag_r;
  assign wr_en       = s2_go && point_store;

  // next obstacle flag, only a stored point moves it
  always_comb begin
    obst_flag_nxt = obst_flag_r;
    if (point_store) begin
      priority if (obst_set) begin
        obst_flag_nxt = 1'b1;
      end else if (obst_clr) begin
        obst_flag_nxt = 1'b0;
      end
    end
  end

  // result index and value per operation
  always_comb begin
    res_index = '0;
    res_value = '0;
    unique case (s2_op_r)
      OP_POINT: begin
        if (s2_accept_r) begin
          res_index = RIDX_W'(s2_idx_r);
          res_value = pt_val;
        end
      end
      OP_READ: begin
        res_index = s2_ridx_r;
        res_value = rd_val;
      end
      OP_ULTRASONIC, OP_TICK: ;
      default: ;
    endcase
  end

  // block state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_valid_r <= '0;
      obst_flag_r <= 1'b0;
      last_us_r   <= LAST_US_RST;
    end else if (s2_go) begin
      obst_flag_r <= obst_flag_nxt;
      if (tick_clear) begin
        bin_valid_r <= '0;
      end else if (point_store) begin
        bin_valid_r[s2_idx_r] <= 1'b1;
      end
      if (s2_op_r == OP_ULTRASONIC) begin
        last_us_r <= (s2_us_r == '0) ? us_no_echo_r : s2_us_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_obstacle_r <= obst_flag_nxt;
      out_accepted_r <= point_store;
      out_index_r    <= res_index;
      out_value_r    <= res_value;
      out_cleared_r  <= tick_clear;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_obstacle       = out_obstacle_r;
  assign out_point_accepted = out_accepted_r;
  assign out_bin_index      = out_index_r;
  assign out_bin_value      = out_value_r;
  assign out_frame_cleared  = out_cleared_r;

endmodule

FILE: rtl/lsbod_chk.sv
// port-level checker for the lidar binning block, bound to the top level
`include "lidar_scan_binning_obstacle_detect_assert.svh"

module lsbod_chk
  import lsbod_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_obstacle,
  input logic              out_point_accepted,
  input logic [RIDX_W-1:0] out_bin_index,
  input logic [DIST_W-1:0] out_bin_value,
  input logic              out_frame_cleared
);

  logic last_obst_r;

  // obstacle flag carried by the last delivered transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_obst_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      last_obst_r <= out_obstacle;
    end
  end

  // a stalled result holds
  `LSBOD_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_obstacle) && $stable(out_point_accepted) && $stable(out_bin_index) && $stable(out_bin_value) && $stable(out_frame_cleared), "result changed while stalled")

  // bins are cleared only while no obstacle is flagged
  `LSBOD_ASSERT_IMP(a_clear_no_obst, out_valid && out_frame_cleared, !out_obstacle && !out_point_accepted && out_bin_index == '0 && out_bin_value == '0, "frame clear with obstacle or bin data")

  // only a stored point may change the obstacle flag
  `LSBOD_ASSERT_IMP(a_flag_hold, out_valid && !out_point_accepted, out_obstacle == last_obst_r, "obstacle flag moved without a stored point")

endmodule

bind lidar_scan_binning_obstacle_detect lsbod_chk u_lsbod_chk (.*);
